>>> src/cmo_pkg.sv
`timescale 1ns / 1ps
// cmo_pkg: shared types and constants of the contact map overlap block
// depends on nothing; used by contact_map_overlap

package cmo_pkg;

	// default capacity of one structure's atom store
	localparam int MAX_ATOMS_DEF = 1024;

	// field widths
	localparam int COORD_W = 25;
	localparam int INDEX_W = 10;
	localparam int COUNT_W = 20;
	localparam int THR_W   = 49;

	// widths of one axis difference, its square and the three-axis sum
	localparam int DIFF_W = COORD_W + 1;
	localparam int SQ_W   = 2 * COORD_W + 1;
	localparam int ACC_W  = SQ_W + 1;

	localparam logic [THR_W-1:0]   THR_RESET = THR_W'(64'd3600000000);
	localparam logic [COUNT_W-1:0] COUNT_MAX = '1;

	// opcode codes
	localparam logic OP_LOAD = 1'b0;
	localparam logic OP_PASS = 1'b1;

	// structure codes
	localparam logic STRUCT_REF = 1'b0;
	localparam logic STRUCT_CMP = 1'b1;

	// one entry of the atom store
	typedef struct packed {
		logic                      present;
		logic signed [COORD_W-1:0] x;
		logic signed [COORD_W-1:0] y;
		logic signed [COORD_W-1:0] z;
	} cmo_atom_t;

	// pass sequencer
	typedef enum logic [9:0] {
		ST_IDLE  = 10'b00_0000_0001,
		ST_CLEAR = 10'b00_0000_0010,
		ST_RD    = 10'b00_0000_0100,
		ST_DIFF  = 10'b00_0000_1000,
		ST_MX    = 10'b00_0001_0000,
		ST_MY    = 10'b00_0010_0000,
		ST_MZ    = 10'b00_0100_0000,
		ST_SUM   = 10'b00_1000_0000,
		ST_DEC   = 10'b01_0000_0000,
		ST_FIN   = 10'b10_0000_0000
	} cmo_state_t;

endpackage

>>> src/contact_map_overlap.sv
`timescale 1ns / 1ps
// load: taken in ST_IDLE, item_ready stays high; pass: one at a time, item_ready low meanwhile
// a pass walks all pairs p < q <= highest index: RD, DIFF, MX, MY, MZ, SUM and DEC for a pair
// of present atoms that needs the distance, RD, DIFF and DEC for a skipped pair, then ST_FIN, which waits
// while an earlier result is still unread; MX, MY and MZ share the single squarer (one axis a cycle)
// reset: present bits of all 2 * 2**ceil(log2 MAX_ATOMS) store entries (2048 by default) swept clear
// with item_ready low; config writes are taken during the sweep

// contact_map_overlap: atom stores, contact bitmap and pair sequencer
// depends on cmo_pkg

module contact_map_overlap #(
	parameter int MAX_ATOMS = cmo_pkg::MAX_ATOMS_DEF
) (
	input  logic                                   clk,
	input  logic                                   arst_n,
	// threshold register write
	input  logic                                   cfg_wr_en,
	input  logic [cmo_pkg::THR_W-1:0]              cfg_wr_data,
	// input items
	input  logic                                   item_valid,
	output logic                                   item_ready,
	input  logic                                   opcode,
	input  logic                                   structure,
	input  logic [cmo_pkg::INDEX_W-1:0]            atom_index,
	input  logic signed [cmo_pkg::COORD_W-1:0]     x_coord,
	input  logic signed [cmo_pkg::COORD_W-1:0]     y_coord,
	input  logic signed [cmo_pkg::COORD_W-1:0]     z_coord,
	// result items
	output logic                                   result_valid,
	input  logic                                   result_ready,
	output logic                                   pass_structure,
	output logic [cmo_pkg::COUNT_W-1:0]            contact_count
);

	// atom index width, store depth (both structures) and bitmap depth
	localparam int IW = $clog2(MAX_ATOMS);
	localparam int SW = IW + 1;
	localparam int SD = 2 << IW;
	localparam int MD = MAX_ATOMS * MAX_ATOMS;
	localparam int MW = $clog2(MD);

	cmo_pkg::cmo_state_t state_q;

	// threshold register
	logic [cmo_pkg::THR_W-1:0] thr_q;

	// highest loaded index per structure
	logic [IW-1:0] hi_q [2];

	// running totals
	logic [cmo_pkg::COUNT_W-1:0] ref_total_q;
	logic [cmo_pkg::COUNT_W-1:0] shr_total_q;

	// bitmap rows and columns at or below this index were written by the last reference pass
	logic [IW-1:0] map_top_q;

	// pass context
	logic          s_q;
	logic [IW-1:0] top_q;
	logic [IW-1:0] pi_q;
	logic [IW-1:0] qi_q;
	logic [MW-1:0] row_q;
	logic [MW-1:0] pos_q;

	// present-bit clearing sweep
	logic [SW-1:0] clr_q;

	// shared squaring unit and accumulator
	logic signed [cmo_pkg::DIFF_W-1:0]   dx_q, dy_q, dz_q;
	logic signed [cmo_pkg::DIFF_W-1:0]   mul_a;
	logic signed [2*cmo_pkg::DIFF_W-1:0] sq_full;
	logic [cmo_pkg::SQ_W-1:0]            prod_q;
	logic [cmo_pkg::ACC_W-1:0]           acc_q;
	logic                                elig_q;
	logic                                close;

	// output register
	logic                        res_valid_q;
	logic                        res_s_q;
	logic [cmo_pkg::COUNT_W-1:0] res_count_q;

	// memories
	cmo_pkg::cmo_atom_t atom_mem [SD];
	logic               map_mem  [MD];
	cmo_pkg::cmo_atom_t at_p_q, at_q_q;
	logic               map_rd_q;

	logic               item_fire;
	logic               load_fire;
	logic               pass_fire;
	logic               idx_ok;
	logic [IW-1:0]      ld_idx;
	logic               mem_we;
	logic [SW-1:0]      mem_wa;
	cmo_pkg::cmo_atom_t mem_wd;
	logic               map_we;
	logic               both_present;
	logic               map_hit;
	logic               out_free;

	assign item_ready = (state_q == cmo_pkg::ST_IDLE);
	assign item_fire  = item_valid && item_ready;
	assign load_fire  = item_fire && (opcode == cmo_pkg::OP_LOAD);
	assign pass_fire  = item_fire && (opcode == cmo_pkg::OP_PASS);

	// loads beyond the store capacity are dropped
	assign idx_ok = (32'(atom_index) < 32'(MAX_ATOMS));
	assign ld_idx = IW'(atom_index);

	// store write port: clearing sweep after reset, else atom loads
	always_comb begin
		mem_we = 1'b0;
		mem_wa = clr_q;
		mem_wd = '0;
		if (state_q == cmo_pkg::ST_CLEAR) begin
			mem_we = 1'b1;
		end else if (load_fire && idx_ok) begin
			mem_we     = 1'b1;
			mem_wa     = {structure, ld_idx};
			mem_wd     = '{present: 1'b1, x: x_coord, y: y_coord, z: z_coord};
		end
	end

	// atom store: one write port, reads for atoms p and q registered
	always_ff @(posedge clk) begin
		if (mem_we) begin
			atom_mem[mem_wa] <= mem_wd;
		end
		at_p_q <= atom_mem[{s_q, pi_q}];
		at_q_q <= atom_mem[{s_q, qi_q}];
	end

	// contact bitmap: written by reference passes, read by comparison passes
	assign close  = elig_q && (acc_q <= cmo_pkg::ACC_W'(thr_q));
	assign map_we = (state_q == cmo_pkg::ST_DEC) && (s_q == cmo_pkg::STRUCT_REF);

	always_ff @(posedge clk) begin
		if (map_we) begin
			map_mem[pos_q] <= close;
		end
		map_rd_q <= map_mem[pos_q];
	end

	// a pair counts for the comparison only if the last reference pass covered and marked it
	assign both_present = at_p_q.present && at_q_q.present;
	assign map_hit      = map_rd_q && (qi_q <= map_top_q);

	// shared squaring unit: one axis a cycle
	always_comb begin
		case (state_q)
			cmo_pkg::ST_MX: mul_a = dx_q;
			cmo_pkg::ST_MY: mul_a = dy_q;
			default:        mul_a = dz_q;
		endcase
	end
	assign sq_full = mul_a * mul_a;

	assign out_free = !res_valid_q || result_ready;

	// datapath registers, no reset needed
	always_ff @(posedge clk) begin
		case (state_q)
			cmo_pkg::ST_DIFF: begin
				dx_q   <= {at_p_q.x[cmo_pkg::COORD_W-1], at_p_q.x}
					- {at_q_q.x[cmo_pkg::COORD_W-1], at_q_q.x};
				dy_q   <= {at_p_q.y[cmo_pkg::COORD_W-1], at_p_q.y}
					- {at_q_q.y[cmo_pkg::COORD_W-1], at_q_q.y};
				dz_q   <= {at_p_q.z[cmo_pkg::COORD_W-1], at_p_q.z}
					- {at_q_q.z[cmo_pkg::COORD_W-1], at_q_q.z};
				elig_q <= both_present && ((s_q == cmo_pkg::STRUCT_REF) || map_hit);
			end
			cmo_pkg::ST_MX: begin
				prod_q <= cmo_pkg::SQ_W'(sq_full);
			end
			cmo_pkg::ST_MY: begin
				acc_q  <= cmo_pkg::ACC_W'(prod_q);
				prod_q <= cmo_pkg::SQ_W'(sq_full);
			end
			cmo_pkg::ST_MZ: begin
				acc_q  <= acc_q + cmo_pkg::ACC_W'(prod_q);
				prod_q <= cmo_pkg::SQ_W'(sq_full);
			end
			cmo_pkg::ST_SUM: begin
				acc_q  <= acc_q + cmo_pkg::ACC_W'(prod_q);
			end
			default: begin
			end
		endcase
	end

	// sequencer, counters and control state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= cmo_pkg::ST_CLEAR;
			thr_q       <= cmo_pkg::THR_RESET;
			hi_q[0]     <= '0;
			hi_q[1]     <= '0;
			ref_total_q <= '0;
			shr_total_q <= '0;
			map_top_q   <= '0;
			s_q         <= cmo_pkg::STRUCT_REF;
			top_q       <= '0;
			pi_q        <= '0;
			qi_q        <= '0;
			row_q       <= '0;
			pos_q       <= '0;
			clr_q       <= '0;
			res_valid_q <= 1'b0;
			res_s_q     <= 1'b0;
			res_count_q <= '0;
		end else begin
			if (cfg_wr_en) begin
				thr_q <= cfg_wr_data;
			end

			// result leaves on its transfer; a finishing pass refills the register itself
			if (res_valid_q && result_ready && (state_q != cmo_pkg::ST_FIN)) begin
				res_valid_q <= 1'b0;
			end

			case (state_q)
				cmo_pkg::ST_CLEAR: begin
					clr_q <= clr_q + 1'b1;
					if (clr_q == SW'(SD - 1)) begin
						state_q <= cmo_pkg::ST_IDLE;
					end
				end

				cmo_pkg::ST_IDLE: begin
					if (load_fire && idx_ok && (ld_idx > hi_q[structure])) begin
						hi_q[structure] <= ld_idx;
					end
					if (pass_fire) begin
						s_q   <= structure;
						top_q <= hi_q[structure];
						pi_q  <= '0;
						qi_q  <= IW'(1);
						row_q <= '0;
						pos_q <= MW'(1);
						// a reference pass rewrites every pair up to its highest index
						if (structure == cmo_pkg::STRUCT_REF) begin
							map_top_q <= hi_q[structure];
						end
						// no pair at all when only index zero can be present
						if (hi_q[structure] == '0) begin
							state_q <= cmo_pkg::ST_FIN;
						end else begin
							state_q <= cmo_pkg::ST_RD;
						end
					end
				end

				cmo_pkg::ST_RD: begin
					state_q <= cmo_pkg::ST_DIFF;
				end

				cmo_pkg::ST_DIFF: begin
					// skip the distance when the pair cannot count
					if (both_present && ((s_q == cmo_pkg::STRUCT_REF) || map_hit)) begin
						state_q <= cmo_pkg::ST_MX;
					end else begin
						state_q <= cmo_pkg::ST_DEC;
					end
				end

				cmo_pkg::ST_MX: begin
					state_q <= cmo_pkg::ST_MY;
				end

				cmo_pkg::ST_MY: begin
					state_q <= cmo_pkg::ST_MZ;
				end

				cmo_pkg::ST_MZ: begin
					state_q <= cmo_pkg::ST_SUM;
				end

				cmo_pkg::ST_SUM: begin
					state_q <= cmo_pkg::ST_DEC;
				end

				cmo_pkg::ST_DEC: begin
					// saturating totals
					if (close) begin
						if (s_q == cmo_pkg::STRUCT_REF) begin
							if (ref_total_q != cmo_pkg::COUNT_MAX) begin
								ref_total_q <= ref_total_q + 1'b1;
							end
						end else if (shr_total_q != cmo_pkg::COUNT_MAX) begin
							shr_total_q <= shr_total_q + 1'b1;
						end
					end
					// next pair
					if (qi_q == top_q) begin
						if (IW'(pi_q + 1'b1) == top_q) begin
							state_q <= cmo_pkg::ST_FIN;
						end else begin
							pi_q    <= IW'(pi_q + 1'b1);
							qi_q    <= IW'(pi_q + 2'd2);
							row_q   <= row_q + MW'(MAX_ATOMS);
							pos_q   <= row_q + MW'(MAX_ATOMS) + MW'(pi_q) + MW'(2);
							state_q <= cmo_pkg::ST_RD;
						end
					end else begin
						qi_q    <= IW'(qi_q + 1'b1);
						pos_q   <= MW'(pos_q + 1'b1);
						state_q <= cmo_pkg::ST_RD;
					end
				end

				cmo_pkg::ST_FIN: begin
					// hold until the output register is free
					if (out_free) begin
						res_valid_q <= 1'b1;
						res_s_q     <= s_q;
						res_count_q <= (s_q == cmo_pkg::STRUCT_REF) ? ref_total_q : shr_total_q;
						state_q     <= cmo_pkg::ST_IDLE;
					end
				end

				default: begin
					state_q <= cmo_pkg::ST_IDLE;
				end
			endcase
		end
	end

	assign result_valid   = res_valid_q;
	assign pass_structure = res_s_q;
	assign contact_count  = res_count_q;

endmodule
